[design/hmn_pkg.sv]
// Shared types and constants for the height map to normal map block.
// No dependencies.
package hmn_pkg;

    localparam int unsigned SMP_W = 8;
    localparam int unsigned DIM_W = 13;
    localparam int unsigned GRD_W = 17;
    localparam int unsigned GZ_W  = 16;
    localparam int unsigned SUM_W = 34;
    localparam int unsigned ROOT_W = 35;
    localparam int unsigned LEN_W = 18;
    localparam int unsigned Q_W   = 9;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FLAT_Z = 2'd2;

    typedef struct packed {
        logic signed [GRD_W-1:0] gx;
        logic signed [GRD_W-1:0] gy;
        logic [GZ_W-1:0]         gz;
        logic                    run_last;
        logic                    frame_last;
    } t_job;

    typedef enum logic [1:0] {F_IDLE, F_READ, F_RIGHT, F_EMIT} t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_SQ, B_SQRT, B_RND, B_DINIT, B_DIV, B_ENC, B_OUT
    } t_bstate;

    function automatic logic signed [GRD_W-1:0] grad(input logic first, input logic last,
            input logic [SMP_W-1:0] l, input logic [SMP_W-1:0] c, input logic [SMP_W-1:0] r);
        logic signed [SMP_W:0] d;
        logic signed [GRD_W-1:0] g;
        if (first) begin
            d = $signed({1'b0, c}) - $signed({1'b0, r});
            g = {d, 8'b0};
        end else if (last) begin
            d = $signed({1'b0, l}) - $signed({1'b0, c});
            g = {d, 8'b0};
        end else begin
            d = $signed({1'b0, l}) - $signed({1'b0, r});
            g = {d[SMP_W], d, 7'b0};
        end
        return g;
    endfunction

    function automatic logic signed [GRD_W-1:0] diff256(input logic [SMP_W-1:0] a,
            input logic [SMP_W-1:0] b);
        logic signed [SMP_W:0] d;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        return {d, 8'b0};
    endfunction

    function automatic logic [GRD_W-1:0] mag(input logic signed [GRD_W-1:0] g);
        return g[GRD_W-1] ? GRD_W'(-g) : GRD_W'(g);
    endfunction

endpackage

[design/heightmap_to_normal_map.sv]
// Top level: height map stream in, encoded normal-map words out.
// Depends on hmn_pkg, hmn_front, hmn_fifo, hmn_back.
//
//  channel | handshake          | payload
//  in      | i_valid / o_ready  | i_height_sample
//  out     | o_valid / i_ready  | o_normal_x/y/z, o_run_last, o_frame_last
//  cfg     | i_cfg_wr_en        | i_cfg_index, i_cfg_data
//
// The front takes a word, reads the row stores, fetches the right neighbour and queues
// its results while the queue has room, then takes the next word. The back runs each
// result through pop, multiply, root steps, rounding, the divider for each component and
// output; a zero length skips the divider. The back's divider sets the sustained rate.
// Synchronous active-low reset clears control; row stores are not cleared.
// A four-word job queue lets the front keep going while the output stalls.
module heightmap_to_normal_map #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [1:0]                i_cfg_index,
    input  logic [15:0]               i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hmn_pkg::SMP_W-1:0] i_height_sample,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hmn_pkg::SMP_W-1:0] o_normal_x,
    output logic [hmn_pkg::SMP_W-1:0] o_normal_y,
    output logic [hmn_pkg::SMP_W-1:0] o_normal_z,
    output logic                      o_run_last,
    output logic                      o_frame_last
);
    import hmn_pkg::*;

    t_job push_job, pop_job;
    logic push, pop, full, empty;

    hmn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_height_sample(i_height_sample),
        .o_push(push), .o_job(push_job), .i_full(full)
    );

    hmn_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .o_full(full), .i_pop(pop), .o_job(pop_job), .o_empty(empty)
    );

    hmn_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(pop_job),
        .o_pop(pop), .o_valid(o_valid), .i_ready(i_ready),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_run_last(o_run_last), .o_frame_last(o_frame_last)
    );
endmodule

[design/hmn_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module hmn_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/hmn_front.sv]
// Front part: takes height samples, keeps the row stores and raster position,
// and queues gradient jobs. Depends on hmn_pkg and hmn_ram.
module hmn_front #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [hmn_pkg::SMP_W-1:0]  i_height_sample,
    output logic                       o_push,
    output hmn_pkg::t_job              o_job,
    input  logic                       i_full
);
    import hmn_pkg::*;
    localparam int unsigned AW = $clog2(MAX_WIDTH);

    t_fstate r_state, n_state;
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [GZ_W-1:0]  r_flat_z;
    logic [DIM_W-1:0] r_col, r_row, r_c, r_r, n_col, n_row;
    logic [SMP_W-1:0] r_s, r_up, r_mid, r_right, r_pm, r_p0, r_p1;
    logic [2:0]       r_pend, n_pend, sel;
    logic [DIM_W-1:0] eff_w, eff_h, c_wrap, r_wrap;
    logic [AW-1:0]    old_raddr, new_raddr;
    logic [SMP_W-1:0] old_rdata, new_rdata;
    logic             ram_we, accept, done;

    always_comb begin
        if (r_cfg_w < DIM_W'(2)) begin
            eff_w = DIM_W'(2);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = r_cfg_w;
        end
        eff_h  = (r_cfg_h < DIM_W'(2)) ? DIM_W'(2) : r_cfg_h;
        c_wrap = (r_col >= eff_w) ? '0 : r_col;
        r_wrap = (r_row >= eff_h) ? '0 : r_row;
    end

    assign accept = i_valid && o_ready;
    assign done   = (r_state == F_EMIT) && (r_pend == 3'b000);

    hmn_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(r_c)), .i_wdata(new_rdata),
        .i_raddr(old_raddr), .o_rdata(old_rdata)
    );
    hmn_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AW'(r_c)), .i_wdata(r_s),
        .i_raddr(new_raddr), .o_rdata(new_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept) n_state = F_READ;
            F_READ:  n_state = F_RIGHT;
            F_RIGHT: n_state = F_EMIT;
            F_EMIT:  if (r_pend == 3'b000) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready   = (r_state == F_IDLE);
        ram_we    = (r_state == F_READ);
        old_raddr = AW'(c_wrap);
        new_raddr = (r_state == F_IDLE) ? AW'(c_wrap) : AW'(r_c + DIM_W'(1));
        sel = r_pend[0] ? 3'b001 : (r_pend[1] ? 3'b010 : (r_pend[2] ? 3'b100 : 3'b000));
        o_push = (r_state == F_EMIT) && (r_pend != 3'b000) && !i_full;
        n_pend = o_push ? (r_pend & ~sel) : r_pend;
        o_job.gz         = r_flat_z;
        o_job.run_last   = (n_pend == 3'b000);
        o_job.frame_last = sel[2];
        priority if (sel[0]) begin
            o_job.gx = grad(r_c == '0, r_c == eff_w - DIM_W'(1), r_pm, r_mid, r_right);
            o_job.gy = (r_r == DIM_W'(1)) ? diff256(r_mid, r_s)
                     : GRD_W'(diff256(r_up, r_s) >>> 1);
        end else if (sel[1]) begin
            o_job.gx = grad(r_c == DIM_W'(1), r_c == eff_w, r_p1, r_p0, r_s);
            o_job.gy = diff256(r_pm, r_p0);
        end else begin
            o_job.gx = diff256(r_p0, r_s);
            o_job.gy = diff256(r_mid, r_s);
        end
        n_col = (r_c + DIM_W'(1) == eff_w) ? '0 : r_c + DIM_W'(1);
        n_row = (r_c + DIM_W'(1) != eff_w) ? r_r
              : ((r_r + DIM_W'(1) == eff_h) ? '0 : r_r + DIM_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_cfg_w  <= DIM_W'(256);
            r_cfg_h  <= DIM_W'(256);
            r_flat_z <= GZ_W'(32768);
            r_col    <= '0;
            r_row    <= '0;
            r_p0     <= '0;
            r_p1     <= '0;
            r_pend   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_s <= i_height_sample;
                r_c <= c_wrap;
                r_r <= r_wrap;
            end
            if (r_state == F_READ) begin
                r_up   <= old_rdata;
                r_mid  <= new_rdata;
                r_pend <= {r_r == eff_h - DIM_W'(1) && r_c == eff_w - DIM_W'(1),
                           r_r == eff_h - DIM_W'(1) && r_c != '0,
                           r_r != '0};
            end else begin
                r_pend <= n_pend;
            end
            if (r_state == F_RIGHT) begin
                r_right <= new_rdata;
            end
            if (done) begin
                r_pm  <= r_mid;
                r_p1  <= r_p0;
                r_p0  <= r_s;
            end
            priority if (i_cfg_wr_en &&
                         (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT)) begin
                r_col <= '0;
                r_row <= '0;
            end else if (done) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_w  <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_cfg_h  <= i_cfg_data[DIM_W-1:0];
                    CFG_FLAT_Z: r_flat_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

[design/hmn_fifo.sv]
// Four word job queue between the front and back parts, show-ahead read.
// Depends on hmn_pkg.
module hmn_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hmn_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output hmn_pkg::t_job o_job,
    output logic          o_empty
);
    import hmn_pkg::*;
    t_job       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end
endmodule

[design/hmn_back.sv]
// Back part: sum of squares, rounded square root, three divisions and encoding.
// Depends on hmn_pkg.
module hmn_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  hmn_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hmn_pkg::SMP_W-1:0] o_normal_x,
    output logic [hmn_pkg::SMP_W-1:0] o_normal_y,
    output logic [hmn_pkg::SMP_W-1:0] o_normal_z,
    output logic                      o_run_last,
    output logic                      o_frame_last
);
    import hmn_pkg::*;

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [1:0]        r_k;
    logic [SUM_W-1:0]  r_prod, r_acc, r_rem;
    logic [ROOT_W-1:0] r_root, sq_t;
    logic [4:0]        r_pos;
    logic [LEN_W-1:0]  r_drem, len;
    logic [LEN_W:0]    rem2;
    logic [Q_W-1:0]    r_dlo, r_q, qc;
    logic [3:0]        r_cnt;
    logic [SMP_W-1:0]  r_enc [3];
    logic [SMP_W-1:0]  enc;
    logic [GRD_W-1:0]  m;
    logic              neg;

    always_comb begin
        unique case (r_k)
            2'd0:    begin m = mag(r_job.gx); neg = r_job.gx[GRD_W-1]; end
            2'd1:    begin m = mag(r_job.gy); neg = r_job.gy[GRD_W-1]; end
            2'd2:    begin m = GRD_W'(r_job.gz); neg = 1'b0; end
            default: begin m = '0; neg = 1'b0; end
        endcase
        sq_t = r_root + (ROOT_W'(1) << {r_pos, 1'b0});
        len  = r_root[LEN_W-1:0];
        rem2 = {r_drem, r_dlo[Q_W-1]};
        qc   = r_q + Q_W'(r_drem != '0);
        if (!neg) begin
            enc = (r_q >= Q_W'(128)) ? SMP_W'(255) : SMP_W'(r_q + Q_W'(128));
        end else begin
            enc = SMP_W'(Q_W'(128) - qc);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_empty) n_state = B_SQ;
            B_SQ:    if (r_k == 2'd3) n_state = B_SQRT;
            B_SQRT:  if (r_pos == '0) n_state = B_RND;
            B_RND:   n_state = B_DINIT;
            B_DINIT: n_state = (len == '0) ? B_OUT : B_DIV;
            B_DIV:   if (r_cnt == '0) n_state = B_ENC;
            B_ENC:   n_state = (r_k == 2'd2) ? B_OUT : B_DINIT;
            B_OUT:   if (i_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = (r_state == B_IDLE) && !i_empty;
        o_valid      = (r_state == B_OUT);
        o_normal_x   = r_enc[0];
        o_normal_y   = r_enc[1];
        o_normal_z   = r_enc[2];
        o_run_last   = r_job.run_last;
        o_frame_last = r_job.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_job  <= i_job;
                r_k    <= '0;
                r_acc  <= '0;
                r_prod <= '0;
            end
            B_SQ: begin
                r_prod <= SUM_W'(m) * SUM_W'(m);
                r_acc  <= r_acc + r_prod;
                r_k    <= r_k + 2'd1;
                r_rem  <= r_acc + r_prod;
                r_root <= '0;
                r_pos  <= 5'd16;
            end
            B_SQRT: begin
                if (ROOT_W'(r_rem) >= sq_t) begin
                    r_rem  <= SUM_W'(ROOT_W'(r_rem) - sq_t);
                    r_root <= (r_root >> 1) + (ROOT_W'(1) << {r_pos, 1'b0});
                end else begin
                    r_root <= r_root >> 1;
                end
                r_pos <= r_pos - 5'd1;
            end
            B_RND: begin
                if (ROOT_W'(r_rem) > r_root) r_root <= r_root + ROOT_W'(1);
                r_k <= '0;
            end
            B_DINIT: begin
                if (len == '0) begin
                    r_enc[0] <= SMP_W'(128);
                    r_enc[1] <= SMP_W'(128);
                    r_enc[2] <= SMP_W'(128);
                end
                r_drem <= LEN_W'(m >> 2);
                r_dlo  <= {m[1:0], 7'b0};
                r_q    <= '0;
                r_cnt  <= 4'(Q_W - 1);
            end
            B_DIV: begin
                if (rem2 >= {1'b0, len}) begin
                    r_drem <= LEN_W'(rem2 - {1'b0, len});
                    r_q    <= {r_q[Q_W-2:0], 1'b1};
                end else begin
                    r_drem <= rem2[LEN_W-1:0];
                    r_q    <= {r_q[Q_W-2:0], 1'b0};
                end
                r_dlo <= r_dlo << 1;
                r_cnt <= r_cnt - 4'd1;
            end
            B_ENC: begin
                r_enc[r_k] <= enc;
                r_k        <= r_k + 2'd1;
            end
            B_OUT: ;
            default: ;
        endcase
    end
endmodule

[bench/tb_heightmap_to_normal_map.sv]
// Testbench for heightmap_to_normal_map: random and directed height rasters, normals checked
// against a predictor in the scoreboard class. Depends on hmn_pkg and the design files.
module tb_heightmap_to_normal_map;
    import hmn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int unsigned ROW_MAX = 4096;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        bit [7:0] x, y, z;
        bit       run_last, frame_last;
    } t_pixel;

    class normal_scoreboard;
        bit [7:0] older_row[ROW_MAX];
        bit [7:0] newer_row[ROW_MAX];
        bit [7:0] prev0, prev1;
        int unsigned col, row, width_reg, height_reg, flat_z;
        t_pixel      expected_q[$];
        int unsigned errors;

        function new();
            col = 0; row = 0; prev0 = 0; prev1 = 0;
            width_reg = 256; height_reg = 256; flat_z = 32768; errors = 0;
        endfunction

        function void configure(bit [1:0] idx, bit [15:0] data);
            if (idx == CFG_WIDTH) begin
                width_reg = data[12:0]; col = 0; row = 0;
            end else if (idx == CFG_HEIGHT) begin
                height_reg = data[12:0]; col = 0; row = 0;
            end else if (idx == CFG_FLAT_Z) begin
                flat_z = data;
            end
        endfunction

        function longint unsigned isqrt_round(longint unsigned n);
            longint unsigned root, bitv, rem;
            root = 0; bitv = 64'd1 << 62; rem = n;
            while (bitv > rem) bitv >>= 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            if (n - root * root > root) root++;
            return root;
        endfunction

        function bit [7:0] encode(longint g, longint unsigned len);
            longint unsigned m;
            longint q;
            m = (g < 0 ? -g : g) * 128;
            if (g >= 0) q = m / len;
            else q = -longint'((m + len - 1) / len);
            q += 128;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            return q[7:0];
        endfunction

        function void push_pixel(longint gx, longint gy, bit frame_end);
            t_pixel p;
            longint gz;
            longint unsigned len;
            gz = flat_z;
            len = isqrt_round(gx * gx + gy * gy + gz * gz);
            if (len == 0) begin
                p.x = 128; p.y = 128; p.z = 128;
            end else begin
                p.x = encode(gx, len); p.y = encode(gy, len); p.z = encode(gz, len);
            end
            p.run_last = 0;
            p.frame_last = frame_end;
            expected_q.push_back(p);
        endfunction

        function longint slope_x(int unsigned x, int unsigned w, longint l, longint c,
                                 longint r);
            if (x == 0) return (c - r) * 256;
            if (x == w - 1) return (l - c) * 256;
            return (l - r) * 128;
        endfunction

        function void note_sample(bit [7:0] smp);
            int unsigned w, h, c, r, n;
            longint s, up, mid, lft, rgt, gy;
            w = width_reg < 2 ? 2 : (width_reg > ROW_MAX ? ROW_MAX : width_reg);
            h = height_reg < 2 ? 2 : height_reg;
            c = col; r = row; s = smp; n = 0;
            if (c >= w) c = 0;
            if (r >= h) r = 0;
            if (r >= 1) begin
                up = older_row[c];
                mid = newer_row[c];
                lft = c >= 1 ? older_row[c-1] : 0;
                rgt = (c + 1 < w) ? newer_row[c+1] : 0;
                gy = (r == 1) ? (mid - s) * 256 : (up - s) * 128;
                push_pixel(slope_x(c, w, lft, mid, rgt), gy, 0);
                n++;
            end
            older_row[c] = newer_row[c];
            newer_row[c] = smp;
            if (r == h - 1) begin
                if (c >= 1) begin
                    lft = (c >= 2) ? prev1 : 0;
                    push_pixel(slope_x(c - 1, w, lft, prev0, s),
                               (longint'(older_row[c-1]) - prev0) * 256, 0);
                    n++;
                end
                if (c == w - 1) begin
                    push_pixel((longint'(prev0) - s) * 256,
                               (longint'(older_row[c]) - s) * 256, 1);
                    n++;
                end
            end
            if (n > 0) expected_q[$].run_last = 1;
            prev1 = prev0;
            prev0 = smp;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col = c; row = r;
        endfunction

        function void check_result(t_pixel got);
            t_pixel exp_p;
            if (expected_q.size() == 0) begin
                $error("normal word with nothing expected");
                errors++;
                return;
            end
            exp_p = expected_q.pop_front();
            if (got.x != exp_p.x) begin
                $error("normal_x exp %0d got %0d", exp_p.x, got.x); errors++;
            end
            if (got.y != exp_p.y) begin
                $error("normal_y exp %0d got %0d", exp_p.y, got.y); errors++;
            end
            if (got.z != exp_p.z) begin
                $error("normal_z exp %0d got %0d", exp_p.z, got.z); errors++;
            end
            if (got.run_last != exp_p.run_last) begin
                $error("run_last exp %0d got %0d", exp_p.run_last, got.run_last); errors++;
            end
            if (got.frame_last != exp_p.frame_last) begin
                $error("frame_last exp %0d got %0d", exp_p.frame_last, got.frame_last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_wr_en = 0;
    logic [1:0]            i_cfg_index = '0;
    logic [15:0]           i_cfg_data = '0;
    logic                  i_valid = 0;
    logic                  o_ready;
    logic [SMP_W-1:0]      i_height_sample = '0;
    logic                  o_valid;
    logic                  i_ready = 0;
    logic [SMP_W-1:0]      o_normal_x, o_normal_y, o_normal_z;
    logic                  o_run_last, o_frame_last;

    normal_scoreboard sb = new();
    bit               idling = 1;
    bit               running = 0;
    int unsigned      stall_left = 0;
    int unsigned      items = 0;
    longint unsigned  cycles = 0;

    heightmap_to_normal_map DUT (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_pixel got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (running) begin
            if (o_valid && i_ready) begin
                got.x = o_normal_x; got.y = o_normal_y; got.z = o_normal_z;
                got.run_last = o_run_last; got.frame_last = o_frame_last;
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                i_ready <= 0;
            end else begin
                i_ready <= 1;
            end
        end
    end

    task automatic send_word(bit [7:0] v);
        int unsigned gap;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_height_sample <= v;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(v);
        items++;
    endtask

    task automatic settle();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(bit [1:0] idx, bit [15:0] data);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.configure(idx, data);
        @(posedge i_clk);
    endtask

    task automatic send_run(int unsigned n, int unsigned mode);
        bit [7:0] v;
        v = 8'($urandom);
        repeat (n) begin
            case (mode)
                0: v = 8'($urandom);
                1: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: v = 8'(v + $urandom_range(0, 6) - 3);
            endcase
            send_word(v);
        end
    endtask

    initial begin
        int unsigned w, h, n, cut, k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        running = 1;
        @(posedge i_clk);

        // directed: extremes, zero length, small-size clamps, bumpiness extremes
        cfg_write(CFG_WIDTH, 16'd3);
        cfg_write(CFG_HEIGHT, 16'd3);
        cfg_write(CFG_FLAT_Z, 16'd32768);
        for (k = 0; k < 9; k++)
            send_word(k[0] ? 8'hFF : 8'h00);
        settle();
        cfg_write(CFG_WIDTH, 16'd0);
        cfg_write(CFG_HEIGHT, 16'd1);
        cfg_write(CFG_FLAT_Z, 16'd0);
        repeat (4) send_word(8'h00);
        settle();
        cfg_write(CFG_FLAT_Z, 16'd1);
        send_word(8'hFF); send_word(8'h00); send_word(8'h00); send_word(8'hFF);
        settle();
        cfg_write(CFG_FLAT_Z, 16'hFFFF);
        cfg_write(CFG_SPARE, 16'h0005);
        cfg_write(CFG_WIDTH, 16'd1);
        send_run(4, 1);
        settle();
        cfg_write(CFG_WIDTH, 16'h1FFF);
        cfg_write(CFG_HEIGHT, 16'd2);
        send_run(6, 0);
        settle();
        cfg_write(CFG_WIDTH, 16'd2);
        cfg_write(CFG_HEIGHT, 16'h1FFF);
        send_run(8, 0);
        settle();

        // random frames, mostly small
        while (items < 480) begin
            idling = items < 400;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
            cfg_write(CFG_WIDTH, 16'(w));
            cfg_write(CFG_HEIGHT, 16'(h));
            case ($urandom_range(0, 5))
                0: cfg_write(CFG_FLAT_Z, $urandom_range(0, 1) ? 16'hFFFF : 16'd1);
                1: cfg_write(CFG_FLAT_Z, 16'($urandom_range(1, 255)));
                default: cfg_write(CFG_FLAT_Z, 16'($urandom));
            endcase
            if (w < 2) w = 2;
            if (h < 2) h = 2;
            n = w * h * $urandom_range(1, 2);
            if (n > 480 - items) n = 480 - items;
            case ($urandom_range(0, 5))
                0: send_run($urandom_range(1, n), 0);
                1: begin
                    cut = $urandom_range(1, n - 1);
                    send_run(cut, 2);
                    settle();
                    cfg_write(CFG_FLAT_Z, 16'($urandom));
                    send_run(n - cut, 2);
                end
                2: send_run(n, 1);
                default: send_run(n, $urandom_range(0, 2));
            endcase
            settle();
        end

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
